// ----- rtl/dnc_pkg.sv -----
// Shared types and constants of the delta energy nearest centroid unit.
package dnc_pkg;

    localparam int SAMPLE_W    = 16;
    localparam int DELTA_W     = SAMPLE_W + 1;
    localparam int SQUARE_W    = 2 * SAMPLE_W;
    localparam int SUM_W       = 40;
    localparam int ROOT_W      = SUM_W / 2;
    localparam int CLASS_W     = 2;
    localparam int REG_COUNT   = 4;
    localparam int CFG_INDEX_W = 2;
    localparam int DEF_LEVELS  = 4;

    localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

    // Register indexes of the configuration port.
    localparam logic [CFG_INDEX_W-1:0] CFG_CENTROID_ZERO  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_CENTROID_ONE   = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_CENTROID_TWO   = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_CENTROID_THREE = 2'd3;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] energy_cost;
        logic                       last_sample;
    } t_in_item;

    typedef struct packed {
        logic [CLASS_W-1:0] class_index;
        logic [ROOT_W-1:0]  root_magnitude;
    } t_out_item;

    typedef logic [REG_COUNT-1:0][ROOT_W-1:0] t_centroid_arr;

endpackage

// ----- rtl/dnc_root.sv -----
// Bit-pair iterative integer square root of the 40-bit sum, one result bit per cycle.
module dnc_root (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [dnc_pkg::SUM_W-1:0]   i_value,
    output logic                        o_done,
    output logic [dnc_pkg::ROOT_W-1:0]  o_root
);
    import dnc_pkg::*;

    localparam int STEPS = ROOT_W;
    localparam int CNT_W = $clog2(STEPS);
    localparam logic [SUM_W-1:0]  BIT_TOP   = {2'b01, {(SUM_W-2){1'b0}}};
    localparam logic [CNT_W-1:0]  LAST_STEP = CNT_W'(STEPS - 1);

    logic [SUM_W-1:0] r_v;
    logic [SUM_W-1:0] r_res;
    logic [SUM_W-1:0] r_bit;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;
    logic [SUM_W:0]   w_trial;
    logic             w_take;

    assign w_trial = {1'b0, r_res} + {1'b0, r_bit};
    assign w_take  = ({1'b0, r_v} >= w_trial);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                if (r_cnt == LAST_STEP) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_v   <= i_value;
            r_res <= '0;
            r_bit <= BIT_TOP;
        end else if (r_busy) begin
            if (w_take) begin
                r_v   <= r_v - w_trial[SUM_W-1:0];
                r_res <= (r_res >> 1) + r_bit;
            end else begin
                r_res <= r_res >> 1;
            end
            r_bit <= r_bit >> 2;
        end
    end

    assign o_done = r_done;
    assign o_root = r_res[ROOT_W-1:0];

endmodule

// ----- rtl/dnc_nearest.sv -----
// Sequential nearest-centroid search, one centroid distance compared per cycle.
module dnc_nearest #(
    parameter int LEVELS = dnc_pkg::DEF_LEVELS
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [dnc_pkg::ROOT_W-1:0]   i_root,
    input  dnc_pkg::t_centroid_arr       i_centroid,
    output logic                         o_done,
    output logic [dnc_pkg::CLASS_W-1:0]  o_class
);
    import dnc_pkg::*;

    // Only REG_COUNT centroids exist; at least one always takes part.
    localparam int NUM = (LEVELS > REG_COUNT) ? REG_COUNT : ((LEVELS < 1) ? 1 : LEVELS);
    localparam logic [CLASS_W-1:0] LAST_IDX = CLASS_W'(NUM - 1);

    logic [CLASS_W-1:0] r_idx;
    logic [CLASS_W-1:0] r_best;
    logic [ROOT_W-1:0]  r_best_dist;
    logic               r_busy;
    logic               r_done;
    logic [ROOT_W-1:0]  w_cent;
    logic [ROOT_W-1:0]  w_dist;

    assign w_cent = i_centroid[r_idx];
    assign w_dist = (i_root > w_cent) ? (i_root - w_cent) : (w_cent - i_root);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_idx  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_idx  <= '0;
            end else if (r_busy) begin
                if (r_idx == LAST_IDX) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_idx <= r_idx + 1'b1;
                end
            end
        end
    end

    // A later centroid wins only on a strictly smaller distance.
    always_ff @(posedge i_clk) begin
        if (r_busy && ((r_idx == '0) || (w_dist < r_best_dist))) begin
            r_best      <= r_idx;
            r_best_dist <= w_dist;
        end
    end

    assign o_done  = r_done;
    assign o_class = r_best;

endmodule

// ----- rtl/delta_energy_nearest_centroid_unit.sv -----
// Top level of the delta energy nearest centroid unit: sequencer, accumulator, output register.
//
// Usage: the samples of one energy-cost vector enter on the input channel, one
// per item, with last_sample set on the final sample. Each sample after the
// first adds the square of its difference to the previous sample to a 40-bit
// saturating sum. On the last sample the block takes the floor square root of
// that sum and emits one item with the index of the nearest of the first LEVELS
// configured centroids, at most four (lower index on a tie), and the root itself.
// A sample that is not last holds o_stall high after it is accepted, through the
// multiply state, then the accumulate state, and only then is a new sample taken.
// A last sample goes on to the root unit, which forms one result bit per cycle,
// then to the search unit, which compares the centroids in turn, and then to the
// output state; most of the time to a result goes to the root iterations.
// The result sits in an output register. A stall from the receiver holds it,
// and the block still accepts the next samples meanwhile; only a new result
// waits for that register to be free. Reset clears the sum, the stored previous
// sample, all centroids and the output valid. Centroids are to be written by the user
// through the configuration port while the block is idle; the block does not enforce it.
module delta_energy_nearest_centroid_unit #(
    parameter int LEVELS = dnc_pkg::DEF_LEVELS
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_stall,
    input  dnc_pkg::t_in_item                i_item,
    output logic                             o_valid,
    input  logic                             i_stall,
    output dnc_pkg::t_out_item               o_item,
    input  logic                             i_cfg_we,
    input  logic [dnc_pkg::CFG_INDEX_W-1:0]  i_cfg_index,
    input  logic [dnc_pkg::ROOT_W-1:0]       i_cfg_data
);
    import dnc_pkg::*;

    // Sequencer states.
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MUL  = 3'd1;
    localparam logic [2:0] S_ADD  = 3'd2;
    localparam logic [2:0] S_ROOT = 3'd3;
    localparam logic [2:0] S_NEAR = 3'd4;
    localparam logic [2:0] S_OUT  = 3'd5;

    logic [2:0]                 r_state;
    logic [2:0]                 n_state;
    logic signed [SAMPLE_W-1:0] r_sample;
    logic                       r_last;
    logic signed [SAMPLE_W-1:0] r_prev;
    logic                       r_have;
    logic [SQUARE_W-1:0]        r_square;
    logic [SUM_W-1:0]           r_sum;
    t_centroid_arr              r_centroid;
    logic                       r_out_valid;
    t_out_item                  r_out;

    logic signed [DELTA_W-1:0]  w_delta;
    logic [DELTA_W-1:0]         w_mag;
    logic [SUM_W:0]             w_sum_wide;
    logic [SUM_W-1:0]           w_sum_sat;
    logic                       w_accept;
    logic                       w_out_free;
    logic                       w_root_start;
    logic                       w_root_done;
    logic [ROOT_W-1:0]          w_root;
    logic                       w_near_start;
    logic                       w_near_done;
    logic [CLASS_W-1:0]         w_class;

    assign w_accept   = i_valid && !o_stall;
    assign w_out_free = !r_out_valid || !i_stall;

    // Neighbour difference and its magnitude; the magnitude fits in 16 bits.
    assign w_delta = {r_sample[SAMPLE_W-1], r_sample} - {r_prev[SAMPLE_W-1], r_prev};
    assign w_mag   = w_delta[DELTA_W-1] ? (-w_delta) : w_delta;

    // Saturating accumulate of the registered square.
    assign w_sum_wide = {1'b0, r_sum} + {{(SUM_W+1-SQUARE_W){1'b0}}, r_square};
    assign w_sum_sat  = w_sum_wide[SUM_W] ? SUM_MAX : w_sum_wide[SUM_W-1:0];

    assign w_root_start = (r_state == S_ADD) && r_last;
    assign w_near_start = (r_state == S_ROOT) && w_root_done;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                n_state = S_ADD;
            end
            S_ADD: begin
                n_state = r_last ? S_ROOT : S_IDLE;
            end
            S_ROOT: begin
                if (w_root_done) begin
                    n_state = S_NEAR;
                end
            end
            S_NEAR: begin
                if (w_near_done) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_prev      <= '0;
            r_have      <= 1'b0;
            r_sum       <= '0;
            r_centroid  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;

            if (i_cfg_we) begin
                r_centroid[i_cfg_index] <= i_cfg_data;
            end

            // The first sample of a vector contributes no square.
            if (r_state == S_ADD) begin
                if (r_last) begin
                    r_prev <= '0;
                    r_have <= 1'b0;
                    r_sum  <= '0;
                end else begin
                    r_prev <= r_sample;
                    r_have <= 1'b1;
                    r_sum  <= w_sum_sat;
                end
            end

            if ((r_state == S_OUT) && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_sample <= i_item.energy_cost;
            r_last   <= i_item.last_sample;
        end
        if (r_state == S_MUL) begin
            r_square <= r_have ? (w_mag[SAMPLE_W-1:0] * w_mag[SAMPLE_W-1:0]) : '0;
        end
        if ((r_state == S_OUT) && w_out_free) begin
            r_out.class_index    <= w_class;
            r_out.root_magnitude <= w_root;
        end
    end

    dnc_root u_root (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_root_start),
        .i_value (w_sum_sat),
        .o_done  (w_root_done),
        .o_root  (w_root)
    );

    dnc_nearest #(
        .LEVELS (LEVELS)
    ) u_nearest (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_near_start),
        .i_root     (w_root),
        .i_centroid (r_centroid),
        .o_done     (w_near_done),
        .o_class    (w_class)
    );

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_out_valid;
    assign o_item  = r_out;

endmodule
